/* rtl/hsdb_pkg.sv */
// Shared types, constants and layer arithmetic for the hit sort and doublet builder.
package hsdb_pkg;

  localparam int unsigned IdW      = 32;
  localparam int unsigned LayerW   = 5;
  localparam int unsigned PosW     = 24;
  localparam int unsigned SqW      = 49;
  localparam int unsigned DistW    = 52;
  localparam int unsigned SkipW    = 6;
  localparam int unsigned CodeW    = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgW     = 24;
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 96;

  // Layer numbering: barrel below BarrelLimit, backward from BackwardStart.
  localparam int unsigned BarrelLimit   = 4;
  localparam int unsigned BackwardStart = 11;
  localparam int unsigned BackwardBase  = 10;
  localparam int unsigned ForwardBase   = 3;
  localparam int unsigned PairScale     = 100;

  typedef enum logic [0:0] {
    MODE_LOAD  = 1'b0,
    MODE_BUILD = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VTX_X = 2'd0,
    REG_VTX_Y = 2'd1,
    REG_VTX_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic capture;
    logic square;
    logic sum;
    logic insert;
    logic scan;
    logic emit;
    logic shift;
    logic flush;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic multi;
    logic run_found;
    logic run_more;
    logic pend_valid;
    logic out_free;
  } sts_t;

  // Number of layers jumped over between inner and outer hit, all ones if invalid.
  function automatic logic [SkipW-1:0] skip_count(input logic [LayerW-1:0] il,
                                                  input logic [LayerW-1:0] ol);
    logic in_bar, out_bar, in_bwd, out_bwd, in_fwd, out_fwd;
    logic [SkipW-1:0] res;
    in_bar  = il < LayerW'(BarrelLimit);
    out_bar = ol < LayerW'(BarrelLimit);
    in_bwd  = !in_bar && (il >= LayerW'(BackwardStart));
    out_bwd = !out_bar && (ol >= LayerW'(BackwardStart));
    in_fwd  = !in_bar && !in_bwd;
    out_fwd = !out_bar && !out_bwd;
    if (il >= ol) begin
      res = '1;
    end else if ((in_bar && out_bar) || (in_fwd && out_fwd) || (in_bwd && out_bwd)) begin
      res = SkipW'(ol) - SkipW'(il) - SkipW'(1);
    end else if (in_bar && out_bwd) begin
      res = SkipW'(ol) - SkipW'(BackwardBase) - SkipW'(1);
    end else if (in_bar) begin
      res = SkipW'(ol) - SkipW'(ForwardBase) - SkipW'(1);
    end else begin
      res = '1;
    end
    return res;
  endfunction

  function automatic logic [CodeW-1:0] pair_code(input logic [LayerW-1:0] il,
                                                 input logic [LayerW-1:0] ol);
    return CodeW'(CodeW'(il) * CodeW'(PairScale)) + CodeW'(ol);
  endfunction

endpackage

/* rtl/hsdb_ctrl.sv */
// Sequencer for loading, sorting and doublet emission.
module hsdb_ctrl
  import hsdb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  input  logic s_mode_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQUARE = 8'b0000_0010,
    ST_SUM    = 8'b0000_0100,
    ST_INSERT = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_EMIT   = 8'b0010_0000,
    ST_SHIFT  = 8'b0100_0000,
    ST_FLUSH  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   prod_ok;

  assign s_tready_o = (state_q == ST_IDLE);
  assign prod_ok    = !sts_i.pend_valid || sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          if (s_mode_i == MODE_BUILD) begin
            state_d = ST_SCAN;
          end else if (!sts_i.full) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        if (!sts_i.multi) begin
          state_d = ST_FLUSH;
        end else if (sts_i.run_found) begin
          cmd_o.scan = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.run_more) begin
          state_d = ST_SHIFT;
        end else if (prod_ok) begin
          cmd_o.emit = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new item is only taken once the previous build has drained its held doublet.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts_i.pend_valid)
    else $error("pending doublet left over in idle");

endmodule

/* rtl/hsdb_datapath.sv */
// Distance computation, sorted hit store, doublet generation and output register.
module hsdb_datapath
  import hsdb_pkg::*;
#(
  parameter int unsigned MaxHits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [IdW-1:0]      hit_id_i,
  input  logic [LayerW-1:0]   layer_id_i,
  input  logic [PosW-1:0]     pos_x_i,
  input  logic [PosW-1:0]     pos_y_i,
  input  logic [PosW-1:0]     pos_z_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic                m_tlast_o
);

  localparam int unsigned CntW = $clog2(MaxHits + 1);
  localparam int unsigned IdxW = (MaxHits > 1) ? $clog2(MaxHits) : 1;
  localparam int unsigned DblW = 2 * IdW + 2 * LayerW + SkipW + CodeW;

  // Configuration.
  logic [PosW-1:0] vtx_x_q, vtx_y_q, vtx_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_x_q <= '0;
      vtx_y_q <= '0;
      vtx_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VTX_X: vtx_x_q <= cfg_data_i;
        REG_VTX_Y: vtx_y_q <= cfg_data_i;
        REG_VTX_Z: vtx_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Distance pipeline.
  logic [IdW-1:0]    new_id_q;
  logic [LayerW-1:0] new_lay_q;
  logic [PosW-1:0]   px_q, py_q, pz_q;
  logic [SqW-1:0]    sqx_q, sqy_q, sqz_q;
  logic [DistW-1:0]  dist_q;
  logic signed [PosW:0]     dx, dy, dz;
  logic signed [2*PosW+1:0] px2, py2, pz2;

  assign dx  = $signed({px_q[PosW-1], px_q}) - $signed({vtx_x_q[PosW-1], vtx_x_q});
  assign dy  = $signed({py_q[PosW-1], py_q}) - $signed({vtx_y_q[PosW-1], vtx_y_q});
  assign dz  = $signed({pz_q[PosW-1], pz_q}) - $signed({vtx_z_q[PosW-1], vtx_z_q});
  assign px2 = dx * dx;
  assign py2 = dy * dy;
  assign pz2 = dz * dz;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_id_q  <= hit_id_i;
      new_lay_q <= layer_id_i;
      px_q      <= pos_x_i;
      py_q      <= pos_y_i;
      pz_q      <= pos_z_i;
    end
    if (cmd_i.square) begin
      sqx_q <= px2[SqW-1:0];
      sqy_q <= py2[SqW-1:0];
      sqz_q <= pz2[SqW-1:0];
    end
    if (cmd_i.sum) begin
      dist_q <= DistW'(sqx_q) + DistW'(sqy_q) + DistW'(sqz_q);
    end
  end

  // Sorted store: entry 0 is the closest hit and, during a build, the inner hit.
  logic [IdW-1:0]    cid_q   [MaxHits];
  logic [LayerW-1:0] clay_q  [MaxHits];
  logic [DistW-1:0]  cdist_q [MaxHits];
  logic [CntW-1:0]   count_q;
  logic [MaxHits-1:0] keep;
  logic [MaxHits-1:0] diff;

  always_comb begin
    for (int k = 0; k < MaxHits; k++) begin
      keep[k] = (CntW'(k) < count_q) && (cdist_q[k] <= dist_q);
      diff[k] = (k != 0) && (CntW'(k) < count_q) && (clay_q[k] != clay_q[0]);
    end
  end

  for (genvar k = 0; k < MaxHits; k++) begin : g_cell
    logic take_new;
    if (k == 0) begin : g_head
      assign take_new = 1'b1;
    end else begin : g_body
      assign take_new = keep[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !keep[k]) begin
        if (take_new) begin
          cid_q[k]   <= new_id_q;
          clay_q[k]  <= new_lay_q;
          cdist_q[k] <= dist_q;
        end else begin
          cid_q[k]   <= cid_q[(k > 0) ? k - 1 : 0];
          clay_q[k]  <= clay_q[(k > 0) ? k - 1 : 0];
          cdist_q[k] <= cdist_q[(k > 0) ? k - 1 : 0];
        end
      end else if (cmd_i.shift && (k < MaxHits - 1)) begin
        cid_q[k]   <= cid_q[(k < MaxHits - 1) ? k + 1 : k];
        clay_q[k]  <= clay_q[(k < MaxHits - 1) ? k + 1 : k];
        cdist_q[k] <= cdist_q[(k < MaxHits - 1) ? k + 1 : k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.insert) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.shift) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // Outer run walk.
  logic [CntW-1:0]   start;
  logic [CntW-1:0]   j_q;
  logic              first_q;
  logic [LayerW-1:0] run_lay_q;
  logic [IdxW-1:0]   j_idx;
  logic [IdW-1:0]    outer_id;
  logic [LayerW-1:0] outer_lay;

  always_comb begin
    start = '0;
    for (int k = MaxHits - 1; k > 0; k--) begin
      if (diff[k]) begin
        start = CntW'(k);
      end
    end
  end

  assign j_idx     = j_q[IdxW-1:0];
  assign outer_id  = cid_q[j_idx];
  assign outer_lay = clay_q[j_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      j_q     <= start;
      first_q <= 1'b1;
    end else if (cmd_i.emit) begin
      j_q       <= j_q + CntW'(1);
      first_q   <= 1'b0;
      run_lay_q <= outer_lay;
    end
  end

  // Held doublet, released as last when the build ends.
  logic [DblW-1:0] pend_q;
  logic            pend_valid_q;
  logic [DblW-1:0] dbl;
  logic            move;
  logic            out_valid_q;
  logic [DblW-1:0] out_q;
  logic            out_last_q;

  assign dbl  = {pair_code(clay_q[0], outer_lay), skip_count(clay_q[0], outer_lay),
                 outer_lay, clay_q[0], outer_id, cid_q[0]};
  assign move = (cmd_i.emit && pend_valid_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pend_q <= dbl;
    end
    if (move) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OutDataW'(out_q);
  assign m_tlast_o  = out_last_q;

  assign sts_o.full       = (count_q == CntW'(MaxHits));
  assign sts_o.multi      = (count_q >= CntW'(2));
  assign sts_o.run_found  = |diff;
  assign sts_o.run_more   = (j_q < count_q) && (first_q || (outer_lay == run_lay_q));
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxHits))
    else $error("hit count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |-> (!out_valid_q || m_tready_i))
    else $error("output register overwritten while held");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (count_q == '0) && !pend_valid_q)
    else $error("store not empty after build");

endmodule

/* rtl/hit_sort_and_doublet_builder.sv */
// Top level of the hit sort and doublet builder: port packing and unit wiring.
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid_i/tready_o     one hit load or one build command
//  m_axis    out        m_axis_tvalid_o/tready_i     one doublet per transaction
//  cfg       in         cfg_we_i (no wait)           production vertex x, y, z
//
// A load runs through capture, squared differences (three 25x25 multipliers), the
// distance sum, and a parallel compare-and-shift insertion into the sorted store. In a
// build every stored hit but the last costs a scan and a shift, plus, when a later run of
// another layer exists, an emit per doublet and a check for the run's end. A final scan
// enters the flush, which releases the held doublet as last and clears the store. The
// single outer-hit read port sets the one-per-cycle rate while the output is not stalled.
// Reset clears the vertex registers, the hit count and all handshake state; the store
// contents are undefined until loaded. A stalled result sink holds back only doublet
// generation and flush; loads proceed while a doublet waits in the output register.
module hit_sort_and_doublet_builder
  import hsdb_pkg::*;
#(
  parameter int unsigned MAX_HITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata from bit 0: hit_id[31:0], layer_id[36:32], pos_x[60:37], pos_y[84:61],
  // pos_z[108:85], zero padding [111:109].
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: mode (0 load, 1 build).
  input  logic                s_axis_tuser_i,
  // Output stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata from bit 0: inner_hit[31:0], outer_hit[63:32], inner_layer[68:64],
  // outer_layer[73:69], skipped_layers[79:74], pair_code[91:80], zeros [95:92].
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the loads and the build walk; the datapath owns all
  // storage and arithmetic and reports back only a handful of status flags.
  hsdb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_mode_i   (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsdb_datapath #(
    .MaxHits (MAX_HITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .hit_id_i   (s_axis_tdata_i[31:0]),
    .layer_id_i (s_axis_tdata_i[36:32]),
    .pos_x_i    (s_axis_tdata_i[60:37]),
    .pos_y_i    (s_axis_tdata_i[84:61]),
    .pos_z_i    (s_axis_tdata_i[108:85]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
